// ----- src/omw_pkg.sv -----
// Shared types, codes and constants for the single-wire bus master.
package omw_pkg;

  // Default widths and depths
  localparam int TIMER_BITS_DEF  = 10;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int CFG_WIDTH       = 10;
  localparam int BYTE_BITS       = 8;

  // Bus command bytes sent by start conversion
  localparam logic [BYTE_BITS-1:0] CMD_SKIP_ROM  = 8'hCC;
  localparam logic [BYTE_BITS-1:0] CMD_CONVERT_T = 8'h44;

  // Register reset values
  localparam logic [CFG_WIDTH-1:0] WRITE_LOW_RST   = 10'd10;
  localparam logic [CFG_WIDTH-1:0] SLOT_SAMPLE_RST = 10'd60;
  localparam logic [CFG_WIDTH-1:0] READ_LOW_RST    = 10'd2;
  localparam logic [CFG_WIDTH-1:0] RESET_PULSE_RST = 10'd480;
  localparam logic [CFG_WIDTH-1:0] RECOVER_RST     = 10'd2;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_RESET   = 3'd1,
    OP_WRITE   = 3'd2,
    OP_READ    = 3'd3,
    OP_CONVERT = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    REG_WRITE_LOW   = 3'd0,
    REG_SLOT_SAMPLE = 3'd1,
    REG_READ_LOW    = 3'd2,
    REG_RESET_PULSE = 3'd3,
    REG_RECOVER     = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_WAIT  = 4'd2,
    PH_RST_POST  = 4'd3,
    PH_GAP       = 4'd4,
    PH_WR_LOW    = 4'd5,
    PH_WR_REST   = 4'd6,
    PH_WR_REC    = 4'd7,
    PH_RD_LOW    = 4'd8,
    PH_RD_SAMPLE = 4'd9,
    PH_RD_REST   = 4'd10,
    PH_RD_REC    = 4'd11
  } phase_t;

  typedef enum logic [2:0] {
    STEP_NONE    = 3'd0,
    STEP_RESET   = 3'd1,
    STEP_SKIP    = 3'd2,
    STEP_CONVERT = 3'd3,
    STEP_POLL    = 3'd4
  } step_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] write_low_us;
    logic [CFG_WIDTH-1:0] slot_sample_us;
    logic [CFG_WIDTH-1:0] read_low_us;
    logic [CFG_WIDTH-1:0] reset_pulse_us;
    logic [CFG_WIDTH-1:0] recover_us;
  } cfg_t;

  typedef struct packed {
    op_t                  op;
    logic [BYTE_BITS-1:0] data;
    logic                 line;
  } cmd_t;

  typedef struct packed {
    logic                 drive_low;
    logic                 busy;
    logic                 done;
    logic [BYTE_BITS-1:0] read_data;
  } res_t;

endpackage

// ----- src/omw_queue.sv -----
// Small first-in first-out queue of packed beats.
module omw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = omw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Store an incoming beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/omw_front.sv -----
// Front end: classifies incoming beats and queues them for the sequencer.
module omw_front #(
  parameter int QUEUE_DEPTH = omw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [2:0]                      operation,
  input  logic [omw_pkg::BYTE_BITS-1:0]   data_in,
  input  logic                            line_level,
  output logic                            cmd_valid,
  input  logic                            cmd_pop,
  output omw_pkg::cmd_t                   cmd
);

  omw_pkg::cmd_t cmd_in;
  logic          cmd_empty;

  // Fold unknown operation codes into a plain tick
  always_comb begin
    cmd_in.data = data_in;
    cmd_in.line = line_level;
    if (operation <= 3'(omw_pkg::OP_CONVERT)) begin
      cmd_in.op = omw_pkg::op_t'(operation);
    end else begin
      cmd_in.op = omw_pkg::OP_TICK;
    end
  end

  omw_queue #(
    .WIDTH ($bits(omw_pkg::cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;

endmodule

// ----- src/omw_back.sv -----
// Back end: bus sequencer, one tick per beat, producing one result per tick.
module omw_back #(
  parameter int TIMER_BITS = omw_pkg::TIMER_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  omw_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  input  omw_pkg::cmd_t cmd,
  input  logic          res_full,
  output logic          res_push,
  output omw_pkg::res_t res
);

  localparam int BB = omw_pkg::BYTE_BITS;

  omw_pkg::phase_t        phase, phase_next;
  logic [TIMER_BITS-1:0]  slot_timer, slot_timer_next;
  logic [2:0]             bit_index, bit_index_next;
  logic [BB-1:0]          shift_byte, shift_byte_next;
  omw_pkg::step_t         seq_step, seq_step_next;
  logic [BB-1:0]          read_result, read_result_next;
  logic                   done;
  logic                   fire;
  logic [TIMER_BITS-1:0]  t_write_low, t_slot_sample, t_read_low, t_reset_pulse, t_recover;

  assign fire     = cmd_valid && !res_full;
  assign cmd_pop  = fire;
  assign res_push = fire;

  // Lengths masked or widened to the timer width
  assign t_write_low   = TIMER_BITS'(cfg.write_low_us);
  assign t_slot_sample = TIMER_BITS'(cfg.slot_sample_us);
  assign t_read_low    = TIMER_BITS'(cfg.read_low_us);
  assign t_reset_pulse = TIMER_BITS'(cfg.reset_pulse_us);
  assign t_recover     = TIMER_BITS'(cfg.recover_us);

  // Hold sequencer state; advance one tick per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= omw_pkg::PH_IDLE;
      slot_timer  <= '0;
      bit_index   <= '0;
      shift_byte  <= '0;
      seq_step    <= omw_pkg::STEP_NONE;
      read_result <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      slot_timer  <= slot_timer_next;
      bit_index   <= bit_index_next;
      shift_byte  <= shift_byte_next;
      seq_step    <= seq_step_next;
      read_result <= read_result_next;
    end
  end

  // Next state for one tick
  always_comb begin
    phase_next       = phase;
    slot_timer_next  = slot_timer;
    bit_index_next   = bit_index;
    shift_byte_next  = shift_byte;
    seq_step_next    = seq_step;
    read_result_next = read_result;
    done             = 1'b0;

    priority if (phase == omw_pkg::PH_IDLE) begin
      // Launch a command
      unique case (cmd.op)
        omw_pkg::OP_RESET: begin
          seq_step_next   = omw_pkg::STEP_NONE;
          phase_next      = omw_pkg::PH_RST_LOW;
          slot_timer_next = t_reset_pulse;
        end
        omw_pkg::OP_WRITE: begin
          seq_step_next   = omw_pkg::STEP_NONE;
          shift_byte_next = cmd.data;
          bit_index_next  = '0;
          phase_next      = omw_pkg::PH_WR_LOW;
          slot_timer_next = t_write_low;
        end
        omw_pkg::OP_READ: begin
          seq_step_next   = omw_pkg::STEP_NONE;
          shift_byte_next = '0;
          bit_index_next  = '0;
          phase_next      = omw_pkg::PH_RD_LOW;
          slot_timer_next = t_read_low;
        end
        omw_pkg::OP_CONVERT: begin
          seq_step_next   = omw_pkg::STEP_RESET;
          phase_next      = omw_pkg::PH_RST_LOW;
          slot_timer_next = t_reset_pulse;
        end
        default: begin
        end
      endcase
    end else if (phase == omw_pkg::PH_RST_WAIT) begin
      // Wait for the presence low
      if (!cmd.line) begin
        phase_next      = omw_pkg::PH_RST_POST;
        slot_timer_next = t_reset_pulse;
      end
    end else if (phase == omw_pkg::PH_RD_SAMPLE) begin
      // Shift in the sampled bit, first bit lands at the bottom
      shift_byte_next = {cmd.line, shift_byte[BB-1:1]};
      phase_next      = omw_pkg::PH_RD_REST;
      slot_timer_next = t_slot_sample;
    end else if (slot_timer > TIMER_BITS'(1)) begin
      slot_timer_next = slot_timer - 1'b1;
    end else begin
      // End of a timed phase
      unique case (phase)
        omw_pkg::PH_RST_LOW: begin
          phase_next      = omw_pkg::PH_RST_WAIT;
          slot_timer_next = '0;
        end
        omw_pkg::PH_RST_POST: begin
          if (seq_step == omw_pkg::STEP_RESET) begin
            phase_next      = omw_pkg::PH_GAP;
            slot_timer_next = t_recover;
          end else begin
            phase_next      = omw_pkg::PH_IDLE;
            slot_timer_next = '0;
            seq_step_next   = omw_pkg::STEP_NONE;
            done            = 1'b1;
          end
        end
        omw_pkg::PH_GAP: begin
          seq_step_next   = omw_pkg::STEP_SKIP;
          shift_byte_next = omw_pkg::CMD_SKIP_ROM;
          bit_index_next  = '0;
          phase_next      = omw_pkg::PH_WR_LOW;
          slot_timer_next = t_write_low;
        end
        omw_pkg::PH_WR_LOW: begin
          phase_next      = omw_pkg::PH_WR_REST;
          slot_timer_next = t_slot_sample;
        end
        omw_pkg::PH_WR_REST: begin
          phase_next      = omw_pkg::PH_WR_REC;
          slot_timer_next = t_recover;
        end
        omw_pkg::PH_WR_REC: begin
          shift_byte_next = {1'b0, shift_byte[BB-1:1]};
          if (bit_index == 3'd7) begin
            bit_index_next = '0;
            if (seq_step == omw_pkg::STEP_SKIP) begin
              seq_step_next   = omw_pkg::STEP_CONVERT;
              shift_byte_next = omw_pkg::CMD_CONVERT_T;
              phase_next      = omw_pkg::PH_WR_LOW;
              slot_timer_next = t_write_low;
            end else if (seq_step == omw_pkg::STEP_CONVERT) begin
              seq_step_next   = omw_pkg::STEP_POLL;
              shift_byte_next = '0;
              phase_next      = omw_pkg::PH_RD_LOW;
              slot_timer_next = t_read_low;
            end else begin
              phase_next      = omw_pkg::PH_IDLE;
              slot_timer_next = '0;
              seq_step_next   = omw_pkg::STEP_NONE;
              done            = 1'b1;
            end
          end else begin
            bit_index_next  = bit_index + 1'b1;
            phase_next      = omw_pkg::PH_WR_LOW;
            slot_timer_next = t_write_low;
          end
        end
        omw_pkg::PH_RD_LOW: begin
          phase_next      = omw_pkg::PH_RD_SAMPLE;
          slot_timer_next = '0;
        end
        omw_pkg::PH_RD_REST: begin
          if (seq_step == omw_pkg::STEP_POLL && shift_byte[BB-1]) begin
            phase_next      = omw_pkg::PH_IDLE;
            slot_timer_next = '0;
            seq_step_next   = omw_pkg::STEP_NONE;
            done            = 1'b1;
          end else begin
            phase_next      = omw_pkg::PH_RD_REC;
            slot_timer_next = t_recover;
          end
        end
        omw_pkg::PH_RD_REC: begin
          if (seq_step == omw_pkg::STEP_POLL) begin
            phase_next      = omw_pkg::PH_RD_LOW;
            slot_timer_next = t_read_low;
          end else if (bit_index == 3'd7) begin
            bit_index_next   = '0;
            read_result_next = shift_byte;
            phase_next       = omw_pkg::PH_IDLE;
            slot_timer_next  = '0;
            seq_step_next    = omw_pkg::STEP_NONE;
            done             = 1'b1;
          end else begin
            bit_index_next  = bit_index + 1'b1;
            phase_next      = omw_pkg::PH_RD_LOW;
            slot_timer_next = t_read_low;
          end
        end
        default: begin
          phase_next      = omw_pkg::PH_IDLE;
          slot_timer_next = '0;
          seq_step_next   = omw_pkg::STEP_NONE;
          done            = 1'b1;
        end
      endcase
    end
  end

  // Drive the result beat from the post-tick state
  always_comb begin
    unique case (phase_next)
      omw_pkg::PH_RST_LOW,
      omw_pkg::PH_WR_LOW,
      omw_pkg::PH_RD_LOW:  res.drive_low = 1'b1;
      omw_pkg::PH_WR_REST: res.drive_low = !shift_byte_next[0];
      default:             res.drive_low = 1'b0;
    endcase
    res.busy      = (phase_next != omw_pkg::PH_IDLE);
    res.done      = done;
    res.read_data = read_result_next;
  end

  // A finishing tick leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    fire && done |=> phase == omw_pkg::PH_IDLE)
    else $error("sequencer not idle after done");

  // Bit counter is parked at zero between commands
  a_idle_bit: assert property (@(posedge clk) disable iff (rst)
    phase == omw_pkg::PH_IDLE |-> bit_index == '0)
    else $error("bit index left nonzero in idle");

  // Polling runs only inside read slots
  a_poll_read: assert property (@(posedge clk) disable iff (rst)
    seq_step == omw_pkg::STEP_POLL |->
      (phase == omw_pkg::PH_RD_LOW || phase == omw_pkg::PH_RD_SAMPLE ||
       phase == omw_pkg::PH_RD_REST || phase == omw_pkg::PH_RD_REC))
    else $error("poll step outside read slot");

  // Presence wait is untimed
  a_wait_timer: assert property (@(posedge clk) disable iff (rst)
    phase == omw_pkg::PH_RST_WAIT |-> slot_timer == '0)
    else $error("timer running during presence wait");

endmodule

// ----- src/one_wire_master.sv -----
// Top level of the single-wire bus master: registers, front end, sequencer, result queue.
//
//   Channel   Handshake          Payload
//   input     push / full        operation, data_in, line_level
//   result    empty / pop        drive_low, busy_res, done_res, read_data
//   config    cfg_we             cfg_index, cfg_data
//
// One beat per clock in and out when neither side stalls. A beat is registered
// in the command queue, then its result in the result queue (empty low).
// The sequencer sets the rate: one bus tick per cycle while results have room.
// rst clears both queues, the sequencer and the timing registers to defaults.
// A full result queue holds the sequencer; the command queue then fills and
// raises full. Each queue holds QUEUE_DEPTH beats.
module one_wire_master #(
  parameter int TIMER_BITS  = omw_pkg::TIMER_BITS_DEF,
  parameter int QUEUE_DEPTH = omw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [2:0]                        operation,
  input  logic [omw_pkg::BYTE_BITS-1:0]     data_in,
  input  logic                              line_level,
  output logic                              empty,
  input  logic                              pop,
  output logic                              drive_low,
  output logic                              busy_res,
  output logic                              done_res,
  output logic [omw_pkg::BYTE_BITS-1:0]     read_data,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [omw_pkg::CFG_WIDTH-1:0]     cfg_data
);

  omw_pkg::cfg_t cfg;
  omw_pkg::cmd_t cmd;
  omw_pkg::res_t res_in;
  omw_pkg::res_t res_out;
  logic          cmd_valid;
  logic          cmd_pop;
  logic          res_full;
  logic          res_push;

  // Timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.write_low_us   <= omw_pkg::WRITE_LOW_RST;
      cfg.slot_sample_us <= omw_pkg::SLOT_SAMPLE_RST;
      cfg.read_low_us    <= omw_pkg::READ_LOW_RST;
      cfg.reset_pulse_us <= omw_pkg::RESET_PULSE_RST;
      cfg.recover_us     <= omw_pkg::RECOVER_RST;
    end else if (cfg_we) begin
      unique case (omw_pkg::cfg_reg_t'(cfg_index))
        omw_pkg::REG_WRITE_LOW:   cfg.write_low_us   <= cfg_data;
        omw_pkg::REG_SLOT_SAMPLE: cfg.slot_sample_us <= cfg_data;
        omw_pkg::REG_READ_LOW:    cfg.read_low_us    <= cfg_data;
        omw_pkg::REG_RESET_PULSE: cfg.reset_pulse_us <= cfg_data;
        omw_pkg::REG_RECOVER:     cfg.recover_us     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  omw_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .data_in    (data_in),
    .line_level (line_level),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd)
  );

  omw_back #(
    .TIMER_BITS (TIMER_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  omw_queue #(
    .WIDTH ($bits(omw_pkg::res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign drive_low = res_out.drive_low;
  assign busy_res  = res_out.busy;
  assign done_res  = res_out.done;
  assign read_data = res_out.read_data;

endmodule

// ----- sim/one_wire_master_test.sv -----
// Self-checking testbench for the single-wire bus master.
module one_wire_master_test;

  localparam int RANDOM_BEATS = 210;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          push = 1'b0;
  logic                          full;
  logic [2:0]                    operation = omw_pkg::OP_TICK;
  logic [omw_pkg::BYTE_BITS-1:0] data_in = '0;
  logic                          line_level = 1'b1;
  logic                          empty;
  logic                          pop = 1'b0;
  logic                          drive_low;
  logic                          busy_res;
  logic                          done_res;
  logic [omw_pkg::BYTE_BITS-1:0] read_data;
  logic                          cfg_we = 1'b0;
  logic [2:0]                    cfg_index = omw_pkg::REG_WRITE_LOW;
  logic [omw_pkg::CFG_WIDTH-1:0] cfg_data = '0;

  one_wire_master uut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .data_in    (data_in),
    .line_level (line_level),
    .empty      (empty),
    .pop        (pop),
    .drive_low  (drive_low),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .read_data  (read_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Bus master state as the testbench tracks it
  omw_pkg::cfg_t                 timing;
  omw_pkg::phase_t               bus_phase;
  logic [omw_pkg::CFG_WIDTH-1:0] slot_count;
  logic [2:0]                    bit_pos;
  logic [7:0]                    shifter;
  omw_pkg::step_t                seq;
  logic [7:0]                    last_read;
  logic                          finished;

  omw_pkg::res_t pending_ticks[$];
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   beats_sent = 0;
  int   results_checked = 0;
  int   commands_run = 0;
  int   errors = 0;

  function automatic void enter_phase(input omw_pkg::phase_t p,
                                      input logic [omw_pkg::CFG_WIDTH-1:0] len);
    bus_phase  = p;
    slot_count = len;
  endfunction

  function automatic void close_command();
    bus_phase  = omw_pkg::PH_IDLE;
    slot_count = '0;
    seq        = omw_pkg::STEP_NONE;
    finished   = 1'b1;
  endfunction

  function automatic void begin_write(input logic [7:0] b);
    shifter = b;
    bit_pos = '0;
    enter_phase(omw_pkg::PH_WR_LOW, timing.write_low_us);
  endfunction

  // Move to the next phase once the current one has run out
  function automatic void end_of_phase();
    case (bus_phase)
      omw_pkg::PH_RST_LOW: enter_phase(omw_pkg::PH_RST_WAIT, '0);
      omw_pkg::PH_RST_POST: begin
        if (seq == omw_pkg::STEP_RESET) enter_phase(omw_pkg::PH_GAP, timing.recover_us);
        else close_command();
      end
      omw_pkg::PH_GAP: begin
        seq = omw_pkg::STEP_SKIP;
        begin_write(omw_pkg::CMD_SKIP_ROM);
      end
      omw_pkg::PH_WR_LOW: enter_phase(omw_pkg::PH_WR_REST, timing.slot_sample_us);
      omw_pkg::PH_WR_REST: enter_phase(omw_pkg::PH_WR_REC, timing.recover_us);
      omw_pkg::PH_WR_REC: begin
        shifter = shifter >> 1;
        if (bit_pos == 3'd7) begin
          bit_pos = '0;
          if (seq == omw_pkg::STEP_SKIP) begin
            seq = omw_pkg::STEP_CONVERT;
            begin_write(omw_pkg::CMD_CONVERT_T);
          end else if (seq == omw_pkg::STEP_CONVERT) begin
            seq     = omw_pkg::STEP_POLL;
            shifter = '0;
            enter_phase(omw_pkg::PH_RD_LOW, timing.read_low_us);
          end else begin
            close_command();
          end
        end else begin
          bit_pos = bit_pos + 3'd1;
          enter_phase(omw_pkg::PH_WR_LOW, timing.write_low_us);
        end
      end
      omw_pkg::PH_RD_LOW: enter_phase(omw_pkg::PH_RD_SAMPLE, '0);
      omw_pkg::PH_RD_REST: begin
        if (seq == omw_pkg::STEP_POLL && shifter[7]) close_command();
        else enter_phase(omw_pkg::PH_RD_REC, timing.recover_us);
      end
      omw_pkg::PH_RD_REC: begin
        if (seq == omw_pkg::STEP_POLL) begin
          enter_phase(omw_pkg::PH_RD_LOW, timing.read_low_us);
        end else if (bit_pos == 3'd7) begin
          bit_pos   = '0;
          last_read = shifter;
          close_command();
        end else begin
          bit_pos = bit_pos + 3'd1;
          enter_phase(omw_pkg::PH_RD_LOW, timing.read_low_us);
        end
      end
      default: close_command();
    endcase
  endfunction

  // Advance the bus master by one tick and return the outputs it shows after it
  function automatic omw_pkg::res_t bus_tick(input logic [2:0] op, input logic [7:0] data,
                                             input logic line);
    omw_pkg::res_t r;
    finished = 1'b0;
    if (bus_phase == omw_pkg::PH_IDLE) begin
      case (op)
        omw_pkg::OP_RESET: begin
          seq = omw_pkg::STEP_NONE;
          enter_phase(omw_pkg::PH_RST_LOW, timing.reset_pulse_us);
        end
        omw_pkg::OP_WRITE: begin
          seq = omw_pkg::STEP_NONE;
          begin_write(data);
        end
        omw_pkg::OP_READ: begin
          seq     = omw_pkg::STEP_NONE;
          shifter = '0;
          bit_pos = '0;
          enter_phase(omw_pkg::PH_RD_LOW, timing.read_low_us);
        end
        omw_pkg::OP_CONVERT: begin
          seq = omw_pkg::STEP_RESET;
          enter_phase(omw_pkg::PH_RST_LOW, timing.reset_pulse_us);
        end
        default: ;
      endcase
    end else if (bus_phase == omw_pkg::PH_RST_WAIT) begin
      if (!line) enter_phase(omw_pkg::PH_RST_POST, timing.reset_pulse_us);
    end else if (bus_phase == omw_pkg::PH_RD_SAMPLE) begin
      shifter = {line, shifter[7:1]};
      enter_phase(omw_pkg::PH_RD_REST, timing.slot_sample_us);
    end else if (slot_count > 1) begin
      slot_count = slot_count - 1'b1;
    end else begin
      end_of_phase();
    end

    case (bus_phase)
      omw_pkg::PH_RST_LOW, omw_pkg::PH_WR_LOW, omw_pkg::PH_RD_LOW: r.drive_low = 1'b1;
      omw_pkg::PH_WR_REST: r.drive_low = ~shifter[0];
      default: r.drive_low = 1'b0;
    endcase
    r.busy      = (bus_phase != omw_pkg::PH_IDLE);
    r.done      = finished;
    r.read_data = last_read;
    return r;
  endfunction

  function automatic void note_failure(input string what);
    errors++;
    if (errors <= 10) $display("mismatch at %0t: %s", $time, what);
  endfunction

  // Drain results at the receiver's pace
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    omw_pkg::res_t want;
    if (!rst && pop && !empty) begin
      if (pending_ticks.size() == 0) begin
        note_failure($sformatf("result beat with nothing expected: drive %0b busy %0b done %0b data %02h",
                               drive_low, busy_res, done_res, read_data));
      end else begin
        want = pending_ticks.pop_front();
        results_checked++;
        if ({drive_low, busy_res, done_res, read_data} !== want)
          note_failure($sformatf("expected drive %0b busy %0b done %0b data %02h, got %0b %0b %0b %02h",
                                 want.drive_low, want.busy, want.done, want.read_data,
                                 drive_low, busy_res, done_res, read_data));
      end
    end
  end

  // Send one tick beat and record what it should produce
  task automatic send_beat(input logic [2:0] op, input logic [7:0] data, input logic line);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    operation  <= op;
    data_in    <= data;
    line_level <= line;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_ticks.push_back(bus_tick(op, data, line));
    beats_sent++;
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain_results();
    push <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_timing(input omw_pkg::cfg_t t);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= omw_pkg::REG_WRITE_LOW;   cfg_data <= t.write_low_us;   @(posedge clk);
    cfg_index <= omw_pkg::REG_SLOT_SAMPLE; cfg_data <= t.slot_sample_us; @(posedge clk);
    cfg_index <= omw_pkg::REG_READ_LOW;    cfg_data <= t.read_low_us;    @(posedge clk);
    cfg_index <= omw_pkg::REG_RESET_PULSE; cfg_data <= t.reset_pulse_us; @(posedge clk);
    cfg_index <= omw_pkg::REG_RECOVER;     cfg_data <= t.recover_us;     @(posedge clk);
    cfg_we <= 1'b0;
    timing = t;
  endtask

  function automatic omw_pkg::cfg_t uniform_timing(input logic [omw_pkg::CFG_WIDTH-1:0] v);
    omw_pkg::cfg_t t;
    t.write_low_us   = v;
    t.slot_sample_us = v;
    t.read_low_us    = v;
    t.reset_pulse_us = v;
    t.recover_us     = v;
    return t;
  endfunction

  // Issue a command from idle and tick until the bus master is idle again.
  // The slave answers read slots from slave_byte, LSB first, and pulls the
  // line low for presence after presence_delay waiting ticks.
  task automatic run_command(input logic [2:0] op, input logic [7:0] data,
                             input logic [7:0] slave_byte, input int presence_delay,
                             input logic [2:0] busy_op);
    int   waited;
    int   sampled;
    logic line;
    waited  = 0;
    sampled = 0;
    send_beat(op, data, 1'($urandom_range(1)));
    commands_run++;
    while (bus_phase != omw_pkg::PH_IDLE) begin
      case (bus_phase)
        omw_pkg::PH_RST_WAIT: begin
          line = (waited >= presence_delay) ? 1'b0 : 1'b1;
          waited++;
        end
        omw_pkg::PH_RD_SAMPLE: begin
          line = slave_byte[sampled % 8];
          sampled++;
        end
        default: line = 1'($urandom_range(1));
      endcase
      send_beat(busy_op, 8'($urandom), line);
    end
  endtask

  task automatic test_idle_ticks();
    send_beat(omw_pkg::OP_TICK, 8'h00, 1'b0);
    send_beat(omw_pkg::OP_TICK, 8'hFF, 1'b1);
    send_beat(3'd5, 8'hFF, 1'b0);
    send_beat(3'd6, 8'h00, 1'b1);
    send_beat(3'd7, 8'hFF, 1'b0);
  endtask

  // Reset values of the timing registers, before any write
  task automatic test_default_timing();
    run_command(omw_pkg::OP_WRITE, 8'hA5, 8'h00, 0, omw_pkg::OP_TICK);
  endtask

  task automatic test_shortest_timing();
    load_timing(uniform_timing(10'd1));
    run_command(omw_pkg::OP_RESET, 8'h00, 8'h00, 3, omw_pkg::OP_TICK);
    run_command(omw_pkg::OP_WRITE, 8'h00, 8'h00, 0, omw_pkg::OP_TICK);
    run_command(omw_pkg::OP_WRITE, 8'hFF, 8'h00, 0, omw_pkg::OP_TICK);
    run_command(omw_pkg::OP_READ, 8'h00, 8'hFF, 0, omw_pkg::OP_TICK);
    run_command(omw_pkg::OP_READ, 8'hFF, 8'h00, 0, omw_pkg::OP_TICK);
    run_command(omw_pkg::OP_CONVERT, 8'h00, 8'h04, 1, omw_pkg::OP_TICK);
  endtask

  // Zero lengths behave like one tick
  task automatic test_zero_lengths();
    load_timing(uniform_timing(10'd0));
    run_command(omw_pkg::OP_CONVERT, 8'h00, 8'h80, 0, omw_pkg::OP_TICK);
    run_command(omw_pkg::OP_WRITE, 8'h5A, 8'h00, 0, omw_pkg::OP_TICK);
    run_command(omw_pkg::OP_READ, 8'h00, 8'h81, 0, omw_pkg::OP_TICK);
  endtask

  // Commands arriving while busy, the done tick included, must be dropped
  task automatic test_busy_commands();
    omw_pkg::cfg_t t;
    t.write_low_us   = 10'd2;
    t.slot_sample_us = 10'd3;
    t.read_low_us    = 10'd1;
    t.reset_pulse_us = 10'd3;
    t.recover_us     = 10'd2;
    load_timing(t);
    run_command(omw_pkg::OP_WRITE, 8'h96, 8'h00, 0, omw_pkg::OP_CONVERT);
    run_command(omw_pkg::OP_READ, 8'h00, 8'hC3, 0, omw_pkg::OP_WRITE);
    run_command(omw_pkg::OP_CONVERT, 8'h00, 8'h02, 4, omw_pkg::OP_READ);
    run_command(omw_pkg::OP_RESET, 8'h00, 8'h00, 0, omw_pkg::OP_RESET);
  endtask

  function automatic logic [omw_pkg::CFG_WIDTH-1:0] random_length();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return omw_pkg::CFG_WIDTH'($urandom_range(0, 3));
    if (pick < 95) return omw_pkg::CFG_WIDTH'($urandom_range(4, 10));
    return omw_pkg::CFG_WIDTH'($urandom_range(11, 40));
  endfunction

  // Mostly well-formed commands with random content, some idle noise
  task automatic test_random_traffic(input int budget);
    omw_pkg::cfg_t t;
    int            start;
    int            in_setting;
    logic [2:0]    op;
    logic [7:0]    slave;
    start      = beats_sent;
    in_setting = 0;
    while (beats_sent - start < budget) begin
      if (in_setting == 0) begin
        t.write_low_us   = random_length();
        t.slot_sample_us = random_length();
        t.read_low_us    = random_length();
        t.reset_pulse_us = random_length();
        t.recover_us     = random_length();
        load_timing(t);
        in_setting = 3;
      end
      if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(1, 4)) begin
          op = 3'($urandom_range(4, 7));
          if (op == omw_pkg::OP_CONVERT) op = omw_pkg::OP_TICK;
          send_beat(op, 8'($urandom), 1'($urandom_range(1)));
        end
      end else begin
        op    = 3'($urandom_range(omw_pkg::OP_RESET, omw_pkg::OP_CONVERT));
        slave = 8'($urandom);
        if (slave == 8'h00) slave = 8'h01 << $urandom_range(7);
        run_command(op, 8'($urandom), slave,
                    ($urandom_range(99) < 70) ? $urandom_range(0, 3) : $urandom_range(4, 20),
                    3'($urandom_range(7)));
        in_setting--;
      end
    end
  endtask

  initial begin
    timing    = uniform_timing('0);
    timing.write_low_us   = omw_pkg::WRITE_LOW_RST;
    timing.slot_sample_us = omw_pkg::SLOT_SAMPLE_RST;
    timing.read_low_us    = omw_pkg::READ_LOW_RST;
    timing.reset_pulse_us = omw_pkg::RESET_PULSE_RST;
    timing.recover_us     = omw_pkg::RECOVER_RST;
    bus_phase  = omw_pkg::PH_IDLE;
    slot_count = '0;
    bit_pos    = '0;
    shifter    = '0;
    seq        = omw_pkg::STEP_NONE;
    last_read  = '0;
    finished   = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 17;
    recv_idle_pct = 74;
    test_idle_ticks();
    test_default_timing();
    test_shortest_timing();
    test_zero_lengths();
    test_busy_commands();
    test_random_traffic(RANDOM_BEATS / 3);

    send_idle_pct = 74;
    recv_idle_pct = 17;
    test_random_traffic(RANDOM_BEATS / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(RANDOM_BEATS / 3);

    // Let the last beats come back, then settle
    drain_results();
    repeat (10) @(posedge clk);

    $display("covered %0d tick beats and %0d bus commands over several timing settings",
             beats_sent, commands_run);
    $display("checked %0d result beats, %0d mismatches", results_checked, errors);
    if (errors == 0 && pending_ticks.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
